// File: hw/rtl/lap_pkg.sv
// ----------------------------------------------------------------------------
// lap_pkg
// Shared types, widths and constants for the 3x3 Laplacian filter.
// ----------------------------------------------------------------------------
package lap_pkg;

  localparam int PIX_W        = 8;
  localparam int IMG_W_BITS   = 11;
  localparam int IMG_H_BITS   = 13;
  localparam int GAIN_BITS    = 10;
  localparam int GAIN_FRAC    = 10;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int SUM_W        = 12;
  localparam int N_RESULTS    = 4;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam logic [IMG_W_BITS-1:0] WIDTH_RESET  = IMG_W_BITS'(1024);
  localparam logic [IMG_H_BITS-1:0] HEIGHT_RESET = IMG_H_BITS'(1024);
  localparam logic [GAIN_BITS-1:0]  GAIN_RESET   = GAIN_BITS'(461);
  localparam logic [PIX_W-1:0]      PIX_MAX      = PIX_W'(255);

  typedef logic [PIX_W-1:0] pixel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_GAIN_Q10     = 2'd2
  } cfg_reg_t;

  // One new window column plus its position flags.
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
    logic   first_col;
    logic   first_row;
    logic   last_col;
    logic   last_row;
  } col_t;

  // One raw kernel response, two's complement.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             eof;
    logic             last;
  } resp_t;

endpackage

// File: hw/rtl/lap_line_buf.sv
// ----------------------------------------------------------------------------
// lap_line_buf
// Raster counters, two line stores and the input register stage. Produces one
// window column (two rows above and the current pixel) per accepted word.
// ----------------------------------------------------------------------------
module lap_line_buf #(
  parameter int MAX_WIDTH  = lap_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lap_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [lap_pkg::IMG_W_BITS-1:0]   image_width,
  input  logic [lap_pkg::IMG_H_BITS-1:0]   image_height,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lap_pkg::pixel_t                  pixel_in,
  output logic                             col_valid,
  input  logic                             col_ready,
  output lap_pkg::col_t                    col
);
  import lap_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WCMP  = (COL_W + 1 > IMG_W_BITS) ? COL_W + 1 : IMG_W_BITS;
  localparam int HCMP  = (ROW_W + 1 > IMG_H_BITS) ? ROW_W + 1 : IMG_H_BITS;

  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;

  pixel_t store_a [MAX_WIDTH];
  pixel_t store_b [MAX_WIDTH];

  logic             s1_valid;
  pixel_t           s1_pixel;
  logic [COL_W-1:0] s1_addr;
  logic             s1_first_col;
  logic             s1_first_row;
  logic             s1_second_row;
  logic             s1_last_col;
  logic             s1_last_row;
  pixel_t           rd_a;
  pixel_t           rd_b;
  logic             byp;
  pixel_t           byp_a;
  pixel_t           byp_b;

  logic [WCMP-1:0] width_ext;
  logic [WCMP-1:0] eff_w;
  logic [HCMP-1:0] height_ext;
  logic [HCMP-1:0] eff_h;
  logic            last_col_in;
  logic            last_row_in;
  logic            in_acc;
  logic            s1_adv;
  pixel_t          line_a;
  pixel_t          line_b;
  pixel_t          above;
  pixel_t          above2;

  always_comb begin
    width_ext  = WCMP'(image_width);
    height_ext = HCMP'(image_height);
    if (width_ext == '0) begin
      eff_w = WCMP'(1);
    end else if (width_ext > WCMP'(MAX_WIDTH)) begin
      eff_w = WCMP'(MAX_WIDTH);
    end else begin
      eff_w = width_ext;
    end
    if (height_ext == '0) begin
      eff_h = HCMP'(1);
    end else if (height_ext > HCMP'(MAX_HEIGHT)) begin
      eff_h = HCMP'(MAX_HEIGHT);
    end else begin
      eff_h = height_ext;
    end
    last_col_in = (WCMP'(col_count) + WCMP'(1)) >= eff_w;
    last_row_in = (HCMP'(row_count) + HCMP'(1)) >= eff_h;
  end

  assign s1_adv   = s1_valid && col_ready;
  assign in_ready = !s1_valid || col_ready;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    line_a = byp ? byp_a : rd_a;
    line_b = byp ? byp_b : rd_b;
    above  = s1_first_row ? s1_pixel : line_a;
    if (s1_first_row) begin
      above2 = s1_pixel;
    end else if (s1_second_row) begin
      above2 = above;
    end else begin
      above2 = line_b;
    end
  end

  assign col_valid     = s1_valid;
  assign col.top       = above2;
  assign col.mid       = above;
  assign col.bot       = s1_pixel;
  assign col.first_col = s1_first_col;
  assign col.first_row = s1_first_row;
  assign col.last_col  = s1_last_col;
  assign col.last_row  = s1_last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      s1_valid  <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid <= 1'b1;
        if (last_col_in) begin
          col_count <= '0;
          row_count <= last_row_in ? '0 : row_count + ROW_W'(1);
        end else begin
          col_count <= col_count + COL_W'(1);
        end
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pixel      <= pixel_in;
      s1_addr       <= col_count;
      s1_first_col  <= (col_count == '0);
      s1_first_row  <= (row_count == '0);
      s1_second_row <= (row_count == ROW_W'(1));
      s1_last_col   <= last_col_in;
      s1_last_row   <= last_row_in;
      byp           <= s1_adv && (s1_addr == col_count);
      byp_a         <= s1_pixel;
      byp_b         <= above;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      store_a[s1_addr] <= s1_pixel;
      store_b[s1_addr] <= above;
    end
    if (in_acc) begin
      rd_a <= store_a[col_count];
      rd_b <= store_b[col_count];
    end
  end

endmodule

// File: hw/rtl/lap_window.sv
// ----------------------------------------------------------------------------
// lap_window
// 3x3 window register and result issue. Each column word yields up to four
// kernel responses, one per cycle while resp_ready is high, border replicated.
// ----------------------------------------------------------------------------
module lap_window (
  input  logic           clk,
  input  logic           rst,
  input  logic           col_valid,
  output logic           col_ready,
  input  lap_pkg::col_t  col,
  output logic           resp_valid,
  input  logic           resp_ready,
  output lap_pkg::resp_t resp
);
  import lap_pkg::*;

  pixel_t win [3][3];
  logic [N_RESULTS-1:0] pending;

  logic [N_RESULTS-1:0] mask_new;
  logic [N_RESULTS-1:0] pick;
  logic [N_RESULTS-1:0] rest;
  logic                 issue;
  logic                 col_acc;
  logic                 col_shift;
  logic                 row_shift;
  pixel_t               cl [3];
  pixel_t               cm [3];
  pixel_t               cr [3];
  pixel_t               t [3][3];
  logic [SUM_W-1:0]     sum;

  always_comb begin
    mask_new[0] = !col.first_col && !col.first_row;
    mask_new[1] = !col.first_col && col.last_row;
    mask_new[2] = col.last_col && !col.first_row;
    mask_new[3] = col.last_col && col.last_row;
  end

  assign pick       = pending & (~pending + N_RESULTS'(1));
  assign rest       = pending & ~pick;
  assign resp_valid = |pending;
  assign issue      = resp_valid && resp_ready;
  assign col_ready  = !resp_valid || (issue && (rest == '0));
  assign col_acc    = col_valid && col_ready;

  assign col_shift = pick[2] | pick[3];
  assign row_shift = pick[1] | pick[3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cl[k] = col_shift ? win[1][k] : win[0][k];
      cm[k] = col_shift ? win[2][k] : win[1][k];
      cr[k] = win[2][k];
    end
    t[0][0] = row_shift ? cl[1] : cl[0];
    t[0][1] = row_shift ? cl[2] : cl[1];
    t[0][2] = cl[2];
    t[1][0] = row_shift ? cm[1] : cm[0];
    t[1][1] = row_shift ? cm[2] : cm[1];
    t[1][2] = cm[2];
    t[2][0] = row_shift ? cr[1] : cr[0];
    t[2][1] = row_shift ? cr[2] : cr[1];
    t[2][2] = cr[2];
    sum = (SUM_W'(t[1][1]) << 3)
        - SUM_W'(t[0][0]) - SUM_W'(t[0][1]) - SUM_W'(t[0][2])
        - SUM_W'(t[1][0]) - SUM_W'(t[1][2])
        - SUM_W'(t[2][0]) - SUM_W'(t[2][1]) - SUM_W'(t[2][2]);
  end

  assign resp.sum  = sum;
  assign resp.eof  = pick[3];
  assign resp.last = (rest == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          win[i][k] <= '0;
        end
      end
    end else begin
      if (col_acc) begin
        pending <= mask_new;
        if (col.first_col) begin
          for (int i = 0; i < 3; i++) begin
            win[i][0] <= col.top;
            win[i][1] <= col.mid;
            win[i][2] <= col.bot;
          end
        end else begin
          for (int k = 0; k < 3; k++) begin
            win[0][k] <= win[1][k];
            win[1][k] <= win[2][k];
          end
          win[2][0] <= col.top;
          win[2][1] <= col.mid;
          win[2][2] <= col.bot;
        end
      end else if (issue) begin
        pending <= rest;
      end
    end
  end

endmodule

// File: hw/rtl/lap_kernel.sv
// ----------------------------------------------------------------------------
// lap_kernel
// Response register, gain multiply, clamp and output register.
// ----------------------------------------------------------------------------
module lap_kernel (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [lap_pkg::GAIN_BITS-1:0]   gain_q10,
  input  logic                            resp_valid,
  output logic                            resp_ready,
  input  lap_pkg::resp_t                  resp,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lap_pkg::pixel_t                 pixel_out,
  output logic                            end_of_frame,
  output logic                            last_in_run
);
  import lap_pkg::*;

  localparam int PROD_W  = SUM_W - 1 + GAIN_BITS;
  localparam int SCALE_W = PROD_W - GAIN_FRAC;

  logic  s3_valid;
  resp_t s3;

  logic               out_free;
  logic               s3_adv;
  logic               positive;
  logic [PROD_W-1:0]  prod;
  logic [SCALE_W-1:0] scaled;
  pixel_t             pix_next;

  assign out_free   = !out_valid || out_ready;
  assign s3_adv     = s3_valid && out_free;
  assign resp_ready = !s3_valid || out_free;

  always_comb begin
    positive = !s3.sum[SUM_W-1] && (s3.sum != '0);
    prod     = PROD_W'(s3.sum[SUM_W-2:0]) * PROD_W'(gain_q10);
    scaled   = prod[PROD_W-1:GAIN_FRAC];
    if (!positive) begin
      pix_next = '0;
    end else if (scaled > SCALE_W'(PIX_MAX)) begin
      pix_next = PIX_MAX;
    end else begin
      pix_next = scaled[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (resp_valid && resp_ready) begin
        s3_valid <= 1'b1;
      end else if (s3_adv) begin
        s3_valid <= 1'b0;
      end
      if (s3_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (resp_valid && resp_ready) begin
      s3 <= resp;
    end
    if (s3_adv) begin
      pixel_out    <= pix_next;
      end_of_frame <= s3.eof;
      last_in_run  <= s3.last;
    end
  end

endmodule

// File: hw/rtl/laplacian_3x3_filter.sv
// ----------------------------------------------------------------------------
// laplacian_3x3_filter
// Streaming 8-neighbour Laplacian with gain and byte clamp.
// ----------------------------------------------------------------------------
// Takes one grayscale pixel per cycle in raster order while in_ready is high,
// and returns filtered pixels one row behind, with edge pixels replicated at
// every border. Output words leave one per cycle while out_ready is high. A
// pixel causes at most one word, but two for the last pixel of each row after
// the first and for every pixel but the first of the final row, and up to four
// for the last pixel of the frame. A new column enters the window only once
// the window has issued every word of the last one. A result word passes the
// input register stage, the window register, the response register and the
// output register. Line stores need no clearing after reset; the block takes words straight away.
// ----------------------------------------------------------------------------
module laplacian_3x3_filter #(
  parameter int MAX_WIDTH  = lap_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lap_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lap_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lap_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lap_pkg::pixel_t                 pixel_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lap_pkg::pixel_t                 pixel_out,
  output logic                            end_of_frame,
  output logic                            last_in_run
);
  import lap_pkg::*;

  logic [IMG_W_BITS-1:0] image_width;
  logic [IMG_H_BITS-1:0] image_height;
  logic [GAIN_BITS-1:0]  gain_q10;

  logic  col_valid;
  logic  col_ready;
  col_t  col;
  logic  resp_valid;
  logic  resp_ready;
  resp_t resp;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      gain_q10     <= GAIN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_H_BITS-1:0];
        REG_GAIN_Q10:     gain_q10     <= cfg_data[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  lap_line_buf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_line_buf (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel_in     (pixel_in),
    .col_valid    (col_valid),
    .col_ready    (col_ready),
    .col          (col)
  );

  lap_window u_window (
    .clk        (clk),
    .rst        (rst),
    .col_valid  (col_valid),
    .col_ready  (col_ready),
    .col        (col),
    .resp_valid (resp_valid),
    .resp_ready (resp_ready),
    .resp       (resp)
  );

  lap_kernel u_kernel (
    .clk          (clk),
    .rst          (rst),
    .gain_q10     (gain_q10),
    .resp_valid   (resp_valid),
    .resp_ready   (resp_ready),
    .resp         (resp),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_out    (pixel_out),
    .end_of_frame (end_of_frame),
    .last_in_run  (last_in_run)
  );

  a_eof_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_frame |-> last_in_run)
    else $error("end of frame word not marked last in run");

  a_stall_has_work: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> resp_valid)
    else $error("input stalled with no responses pending");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

// File: dv/laplacian_3x3_filter_tb.sv
// ----------------------------------------------------------------------------
// laplacian_3x3_filter_tb
// Self-checking bench for the streaming 3x3 Laplacian filter.
// ----------------------------------------------------------------------------
// Pixels are driven in raster order frame by frame. A bit-accurate copy of
// the line stores, window and counters predicts every output word:
// pixel_out, end_of_frame and last_in_run. Directed frames come first:
// extreme pixels and gains, a one-pixel frame and a single-row frame, and
// a width and a height cut short mid-frame. Random small frames follow,
// then a width above its limit, cut short after a few pixels, and a height
// of 13'd8193, which truncates to one. Both sides stall at random. In one
// frame the output is held back long enough to back up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module laplacian_3x3_filter_tb;
  import lap_pkg::*;

  localparam int          CLK_HALF    = 10;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int          DRAIN_WAIT  = 8;
  localparam int          HOLD_LEN    = 400;

  typedef struct {
    pixel_t pix;
    logic   eof;
    logic   last;
  } lap_word_t;

  class lap_scoreboard;
    pixel_t                  row_above[MAX_WIDTH_DEF];
    pixel_t                  row_above2[MAX_WIDTH_DEF];
    pixel_t                  win[3][3];
    int unsigned             col_n;
    int unsigned             row_n;
    logic [IMG_W_BITS-1:0]   width_reg;
    logic [IMG_H_BITS-1:0]   height_reg;
    logic [GAIN_BITS-1:0]    gain_reg;
    lap_word_t               pending[$];
    int                      errors;

    function new();
      foreach (row_above[i]) begin
        row_above[i]  = '0;
        row_above2[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col_n      = 0;
      row_n      = 0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      gain_reg   = GAIN_RESET;
      errors     = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg  = v[IMG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: height_reg = v[IMG_H_BITS-1:0];
        REG_GAIN_Q10:     gain_reg   = v[GAIN_BITS-1:0];
        default: ;
      endcase
    endfunction

    function bit frame_start();
      return col_n == 0 && row_n == 0;
    endfunction

    // Window columns and rows are given left..right and top..bottom.
    function pixel_t respond(int c0, int c1, int c2, int r0, int r1, int r2);
      int cs[3];
      int rs[3];
      int sum;
      int v;
      cs[0] = c0; cs[1] = c1; cs[2] = c2;
      rs[0] = r0; rs[1] = r1; rs[2] = r2;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (i == 1 && j == 1) sum += 8 * int'(win[cs[j]][rs[i]]);
          else sum -= int'(win[cs[j]][rs[i]]);
        end
      end
      if (sum <= 0) return '0;
      v = (sum * int'(gain_reg)) >>> GAIN_FRAC;
      if (v > 255) v = 255;
      return pixel_t'(v);
    endfunction

    function void push_word(pixel_t p, logic eof);
      lap_word_t w;
      w.pix  = p;
      w.eof  = eof;
      w.last = 1'b0;
      pending.push_back(w);
    endfunction

    function void note_pixel(pixel_t x);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      pixel_t      above;
      pixel_t      above2;
      bit          last_col;
      bit          last_row;
      int          start;
      w = (width_reg == 0) ? 1 :
          (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_reg);
      h = (height_reg == 0) ? 1 :
          (height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(height_reg);
      c = (col_n >= MAX_WIDTH_DEF) ? MAX_WIDTH_DEF - 1 : col_n;
      r = row_n;
      if (r == 0) begin
        above  = x;
        above2 = x;
      end else if (r == 1) begin
        above  = row_above[c];
        above2 = above;
      end else begin
        above  = row_above[c];
        above2 = row_above2[c];
      end
      row_above2[c] = above;
      row_above[c]  = x;
      for (int k = 0; k < 3; k++) begin
        win[0][k] = win[1][k];
        win[1][k] = win[2][k];
      end
      win[2][0] = above2;
      win[2][1] = above;
      win[2][2] = x;
      // replicate the left edge
      if (c == 0) begin
        for (int k = 0; k < 3; k++) begin
          win[0][k] = win[2][k];
          win[1][k] = win[2][k];
        end
      end
      last_col = (c + 1 >= w);
      last_row = (r + 1 >= h);
      start = pending.size();
      if (c >= 1) begin
        if (r >= 1) push_word(respond(0, 1, 2, 0, 1, 2), 1'b0);
        if (last_row) push_word(respond(0, 1, 2, 1, 2, 2), 1'b0);
      end
      if (last_col) begin
        if (r >= 1) push_word(respond(1, 2, 2, 0, 1, 2), 1'b0);
        if (last_row) push_word(respond(1, 2, 2, 1, 2, 2), 1'b1);
      end
      if (pending.size() > start) pending[pending.size() - 1].last = 1'b1;
      if (last_col) begin
        col_n = 0;
        row_n = last_row ? 0 : r + 1;
      end else begin
        col_n = c + 1;
      end
    endfunction

    function void check_result(pixel_t pix, logic eof, logic last);
      lap_word_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, pixel_out %0d end_of_frame %0b last_in_run %0b",
                 $time, pix, eof, last);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (pix !== w.pix) begin
        $display("%0t: pixel_out expected %0d, got %0d", $time, w.pix, pix);
        errors++;
      end
      if (eof !== w.eof) begin
        $display("%0t: end_of_frame expected %0b, got %0b", $time, w.eof, eof);
        errors++;
      end
      if (last !== w.last) begin
        $display("%0t: last_in_run expected %0b, got %0b", $time, w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  pixel_t                pixel_in;
  logic                  out_valid;
  logic                  out_ready;
  pixel_t                pixel_out;
  logic                  end_of_frame;
  logic                  last_in_run;

  lap_scoreboard sb = new();
  bit            steady;
  bit            hold_req;
  int unsigned   cycles;
  pixel_t        run[$];

  laplacian_3x3_filter DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel_in     (pixel_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_out    (pixel_out),
    .end_of_frame (end_of_frame),
    .last_in_run  (last_in_run)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[laplacian_3x3_filter] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(pixel_out, end_of_frame, last_in_run);
  end

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic pixel_t pick_pixel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return PIX_MAX;
    return pixel_t'($urandom_range(0, 255));
  endfunction

  function automatic logic [GAIN_BITS-1:0] pick_gain();
    int r;
    r = $urandom_range(0, 4);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return GAIN_BITS'($urandom_range(0, 1023));
  endfunction

  // receiver: random stalls, long hold on request
  initial begin
    int   hold_left;
    int   stall_left;
    logic rdy;
    hold_left  = 0;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_LEN;
        hold_req  = 1'b0;
      end
      if (rst) begin
        rdy = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (steady) begin
        rdy = 1'b1;
      end else begin
        stall_left = draw_gap();
        rdy = (stall_left == 0);
      end
      out_ready <= rdy;
    end
  end

  // Called at a rising edge; returns after the word is taken and any input gap.
  task automatic send_pixel(input pixel_t p);
    int gap;
    in_valid <= 1'b1;
    pixel_in <= p;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(p);
    gap = steady ? 0 : draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame();
    do send_pixel(pick_pixel()); while (!sb.frame_start());
  endtask

  task automatic send_run();
    foreach (run[i]) send_pixel(run[i]);
  endtask

  // hold the input until every expected word is out, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_config(input logic [IMG_W_BITS-1:0] w,
                              input logic [IMG_H_BITS-1:0] h,
                              input logic [GAIN_BITS-1:0]  g);
    cfg_reg_t                idx[3];
    logic [CFG_DATA_W-1:0]   val[3];
    idx[0] = REG_IMAGE_WIDTH;  val[0] = CFG_DATA_W'(w);
    idx[1] = REG_IMAGE_HEIGHT; val[1] = CFG_DATA_W'(h);
    idx[2] = REG_GAIN_Q10;     val[2] = CFG_DATA_W'(g);
    for (int i = 0; i < 3; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      sb.set_reg(idx[i], val[i]);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  initial begin
    int items;
    int frame_no;
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    pixel_in  <= '0;
    steady    = 1'b0;
    hold_req  = 1'b0;
    cycles    = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // extreme pixels at full gain
    write_config(11'd4, 13'd3, 10'd1023);
    run = {8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255,
           8'd255, 8'd255, 8'd0, 8'd0};
    send_run();
    // zero sizes act as one: a single-pixel frame
    settle();
    write_config(11'd0, 13'd0, 10'd461);
    send_pixel(8'd200);
    // single-row frame with zero gain
    settle();
    write_config(11'd3, 13'd1, 10'd0);
    run = {8'd0, 8'd255, 8'd17};
    send_run();
    settle();
    write_config(11'd2, 13'd2, 10'd1);
    run = {8'd255, 8'd0, 8'd0, 8'd0};
    send_run();

    // width cut short partway through a row
    settle();
    write_config(11'd5, 13'd4, 10'd700);
    repeat (12) send_pixel(pick_pixel());
    settle();
    write_config(11'd2, 13'd4, 10'd700);
    send_frame();
    // height cut short partway through a frame
    settle();
    write_config(11'd3, 13'd6, 10'd300);
    repeat (10) send_pixel(pick_pixel());
    settle();
    write_config(11'd3, 13'd2, 10'd300);
    send_frame();

    items    = 0;
    frame_no = 0;
    while (items < 320) begin
      steady = ($urandom_range(0, 3) == 0);
      if (frame_no == 3) begin
        steady = 1'b0;
        settle();
        write_config(11'd12, 13'd8, pick_gain());
        hold_req = 1'b1;
      end else if (frame_no == 0 || $urandom_range(0, 2) == 0) begin
        settle();
        write_config(IMG_W_BITS'($urandom_range(0, 12)), IMG_H_BITS'($urandom_range(0, 8)),
                     pick_gain());
      end else if (frame_no == 6) begin
        settle();
      end
      do begin
        send_pixel(pick_pixel());
        items++;
      end while (!sb.frame_start());
      frame_no++;
    end

    // width above its limit, cut short, then a height of 13'd8193 that truncates to one
    steady = 1'b0;
    settle();
    write_config(11'd1025, 13'd2, 10'd1023);
    repeat (6) send_pixel(pick_pixel());
    settle();
    write_config(11'd3, 13'd2, 10'd1023);
    send_frame();
    settle();
    write_config(11'd1, 13'd8193, 10'd461);
    repeat (6) send_pixel(pick_pixel());
    settle();
    write_config(11'd1, 13'd2, 10'd461);
    send_frame();

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4 * DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[laplacian_3x3_filter] OK");
    end else begin
      $display("[laplacian_3x3_filter] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/lap_pkg.sv
hw/rtl/lap_line_buf.sv
hw/rtl/lap_window.sv
hw/rtl/lap_kernel.sv
hw/rtl/laplacian_3x3_filter.sv
dv/laplacian_3x3_filter_tb.sv
